// ----- design/look_at_view_matrix_top_assert.svh -----
// assertion macros shared by the look-at view matrix checker
// expects clk_i and rst_ni in the scope of use
`ifndef LOOK_AT_VIEW_MATRIX_TOP_ASSERT_SVH
`define LOOK_AT_VIEW_MATRIX_TOP_ASSERT_SVH

// same-cycle implication
`define LVM_ASSERT_IMP(name, pre, post) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error("look-at view matrix check failed");

// next-cycle implication
`define LVM_ASSERT_NXT(name, pre, post) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error("look-at view matrix check failed");

`endif

// ----- design/lvm_pkg.sv -----
// shared types and constants of the look-at view matrix block
// no dependencies
`default_nettype none
package lvm_pkg;

  localparam logic [31:0] AxisOne = 32'h4000_0000;
  localparam logic [1:0]  RowLast = 2'd2;

  typedef struct packed {
    logic [2:0][31:0] origin;
    logic [2:0][31:0] dir;
    logic [2:0][31:0] up;
    logic             dir_zero;
  } item_t;

  typedef struct packed {
    logic             start;
    logic [2:0][63:0] vec;
  } norm_req_t;

  typedef struct packed {
    logic             done;
    logic             ok;
    logic [2:0][31:0] axis;
  } norm_rsp_t;

endpackage
`default_nettype wire

// ----- design/lvm_front.sv -----
// input side: classifies items and holds them in a two-entry queue
// depends on lvm_pkg
`default_nettype none
module lvm_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [2:0][31:0]  origin_i,
  input  logic [2:0][31:0]  dir_i,
  input  logic [2:0][31:0]  up_i,
  input  logic              pop_i,
  output logic              item_valid_o,
  output lvm_pkg::item_t    item_o
);
  import lvm_pkg::*;

  item_t      mem_q [2];
  logic       wptr_q, wptr_d;
  logic       rptr_q, rptr_d;
  logic [1:0] cnt_q, cnt_d;
  logic       push;
  logic       pop;
  item_t      item_in;

  assign in_ready_o   = (cnt_q != 2'd2);
  assign item_valid_o = (cnt_q != 2'd0);
  assign item_o       = mem_q[rptr_q];
  assign push         = in_valid_i && in_ready_o;
  assign pop          = pop_i && item_valid_o;

  always_comb begin
    item_in.origin   = origin_i;
    item_in.dir      = dir_i;
    item_in.up       = up_i;
    item_in.dir_zero = ~|dir_i;
    wptr_d = push ? ~wptr_q : wptr_q;
    rptr_d = pop ? ~rptr_q : rptr_q;
    cnt_d  = cnt_q + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wptr_q] <= item_in;
    end
  end

endmodule
`default_nettype wire

// ----- design/lvm_norm.sv -----
// vector normaliser: exponent scan, bit-serial square root, serial divider
// depends on lvm_pkg
`default_nettype none
module lvm_norm (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  lvm_pkg::norm_req_t req_i,
  output lvm_pkg::norm_rsp_t rsp_o
);
  import lvm_pkg::*;

  typedef enum logic [2:0] {
    N_IDLE, N_SCAN, N_SHIFT, N_SQUARE, N_ROOT, N_DLOAD, N_DIV
  } nstate_e;

  nstate_e          state_q;
  logic [2:0]       neg_q;
  logic [2:0][62:0] mag_q;
  logic [62:0]      or_q;
  logic [5:0]       bl_q;
  logic [4:0]       cnt_q;
  logic [1:0]       comp_q;
  logic [63:0]      sum_q;
  logic [63:0]      x_q;
  logic [63:0]      r_q;
  logic [63:0]      rbit_q;
  logic [32:0]      len_q;
  logic [33:0]      rem_q;
  logic [31:0]      lo_q;
  logic [31:0]      quo_q;
  logic [2:0][31:0] axis_q;
  logic             done_q;
  logic             ok_q;

  logic [2:0][62:0] mag_w;
  logic [62:0]      or_w;
  logic [6:0]       cand;
  logic             hit;
  logic [2:0][27:0] m28;
  logic [55:0]      sq;
  logic [63:0]      sum_w;
  logic [63:0]      rb;
  logic             rge;
  logic [63:0]      x_next;
  logic [63:0]      r_next;
  logic [61:0]      num_w;
  logic [34:0]      trial;
  logic             ge;
  logic [33:0]      rem_next;
  logic [31:0]      quo_next;
  logic [31:0]      q_clamp;
  logic [31:0]      axis_w;

  assign rsp_o.done = done_q;
  assign rsp_o.ok   = ok_q;
  assign rsp_o.axis = axis_q;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      mag_w[i] = req_i.vec[i][63] ? 63'(-req_i.vec[i]) : req_i.vec[i][62:0];
      if (bl_q >= 6'd28) begin
        m28[i] = 28'(mag_q[i] >> (bl_q - 6'd27));
      end else begin
        m28[i] = 28'(mag_q[i] << (6'd27 - bl_q));
      end
    end
    or_w  = mag_w[0] | mag_w[1] | mag_w[2];
    cand  = {1'b0, bl_q} + (7'd32 >> cnt_q[2:0]);
    hit   = |(or_q >> cand);
    sq    = mag_q[comp_q][27:0] * mag_q[comp_q][27:0];
    sum_w = sum_q + 64'(sq);
    rb    = r_q + rbit_q;
    rge   = (x_q >= rb);
    x_next = rge ? (x_q - rb) : x_q;
    r_next = rge ? ((r_q >> 1) + rbit_q) : (r_q >> 1);
    num_w = 62'({mag_q[comp_q][27:0], 33'd0}) + 62'(len_q >> 1);
    trial = {rem_q, lo_q[31]};
    ge    = (trial >= {2'b00, len_q});
    rem_next = ge ? 34'(trial - {2'b00, len_q}) : trial[33:0];
    quo_next = {quo_q[30:0], ge};
    q_clamp  = (quo_next > AxisOne) ? AxisOne : quo_next;
    axis_w   = neg_q[comp_q] ? (~q_clamp + 32'd1) : q_clamp;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= N_IDLE;
      neg_q   <= '0;
      mag_q   <= '0;
      or_q    <= '0;
      bl_q    <= '0;
      cnt_q   <= '0;
      comp_q  <= '0;
      sum_q   <= '0;
      x_q     <= '0;
      r_q     <= '0;
      rbit_q  <= '0;
      len_q   <= '0;
      rem_q   <= '0;
      lo_q    <= '0;
      quo_q   <= '0;
      axis_q  <= '0;
      done_q  <= 1'b0;
      ok_q    <= 1'b0;
    end else begin
      done_q <= 1'b0;
      case (state_q)
        N_IDLE: begin
          if (req_i.start) begin
            for (int i = 0; i < 3; i++) begin
              neg_q[i] <= req_i.vec[i][63];
            end
            mag_q <= mag_w;
            or_q  <= or_w;
            bl_q  <= '0;
            cnt_q <= '0;
            if (or_w == '0) begin
              done_q <= 1'b1;
              ok_q   <= 1'b0;
            end else begin
              state_q <= N_SCAN;
            end
          end
        end
        N_SCAN: begin
          if (hit) begin
            bl_q <= cand[5:0];
          end
          cnt_q <= cnt_q + 5'd1;
          if (cnt_q == 5'd5) begin
            state_q <= N_SHIFT;
          end
        end
        N_SHIFT: begin
          for (int i = 0; i < 3; i++) begin
            mag_q[i] <= 63'(m28[i]);
          end
          comp_q  <= '0;
          sum_q   <= '0;
          state_q <= N_SQUARE;
        end
        N_SQUARE: begin
          sum_q  <= sum_w;
          comp_q <= comp_q + 2'd1;
          if (comp_q == 2'd2) begin
            x_q     <= sum_w << 6;
            r_q     <= '0;
            rbit_q  <= 64'h4000_0000_0000_0000;
            cnt_q   <= '0;
            comp_q  <= '0;
            state_q <= N_ROOT;
          end
        end
        N_ROOT: begin
          x_q    <= x_next;
          r_q    <= r_next;
          rbit_q <= rbit_q >> 2;
          cnt_q  <= cnt_q + 5'd1;
          if (cnt_q == 5'd31) begin
            len_q   <= r_next[32:0];
            state_q <= N_DLOAD;
          end
        end
        N_DLOAD: begin
          rem_q   <= 34'(num_w[61:32]);
          lo_q    <= num_w[31:0];
          quo_q   <= '0;
          cnt_q   <= '0;
          state_q <= N_DIV;
        end
        N_DIV: begin
          rem_q <= rem_next;
          lo_q  <= lo_q << 1;
          quo_q <= quo_next;
          cnt_q <= cnt_q + 5'd1;
          if (cnt_q == 5'd31) begin
            axis_q[comp_q] <= axis_w;
            if (comp_q == 2'd2) begin
              done_q  <= 1'b1;
              ok_q    <= 1'b1;
              state_q <= N_IDLE;
            end else begin
              comp_q  <= comp_q + 2'd1;
              state_q <= N_DLOAD;
            end
          end
        end
        default: begin
          state_q <= N_IDLE;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

// ----- design/lvm_back.sv -----
// back end: sequencer, shared 32x32 multiply-accumulate and output register
// depends on lvm_pkg and drives lvm_norm through its request struct
`default_nettype none
module lvm_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               item_valid_i,
  input  lvm_pkg::item_t     item_i,
  output logic               item_pop_o,
  output lvm_pkg::norm_req_t nreq_o,
  input  lvm_pkg::norm_rsp_t nrsp_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [1:0]         row_o,
  output logic [31:0]        axis_x_o,
  output logic [31:0]        axis_y_o,
  output logic [31:0]        axis_z_o,
  output logic [31:0]        translation_o,
  output logic               degenerate_o,
  output logic               last_o
);
  import lvm_pkg::*;

  typedef enum logic [2:0] {
    B_IDLE, B_NORM_Z, B_MUL, B_ACC, B_NORM_X, B_EMIT
  } bstate_e;

  typedef enum logic [1:0] {PH_T, PH_Y, PH_D} phase_e;

  localparam int unsigned AxisFrac = 30;
  localparam logic signed [63:0] AxisHi = 64'sh4000_0000;
  localparam logic signed [63:0] AxisLo = -64'sh4000_0000;
  localparam logic signed [63:0] TrHi   = 64'sh7FFF_FFFF;
  localparam logic signed [63:0] TrLo   = -64'sh8000_0000;

  function automatic logic signed [63:0] round30(input logic signed [63:0] v);
    logic [63:0] m;
    logic [63:0] r;
    m = v[63] ? 64'(-v) : 64'(v);
    r = (m + (64'd1 << (AxisFrac - 1))) >> AxisFrac;
    return v[63] ? -$signed(r) : $signed(r);
  endfunction

  function automatic logic [31:0] clamp_axis(input logic signed [63:0] v);
    logic signed [63:0] c;
    c = v;
    if (v > AxisHi) c = AxisHi;
    if (v < AxisLo) c = AxisLo;
    return c[31:0];
  endfunction

  function automatic logic [31:0] sat32(input logic signed [63:0] v);
    logic signed [63:0] c;
    c = v;
    if (v > TrHi) c = TrHi;
    if (v < TrLo) c = TrLo;
    return c[31:0];
  endfunction

  function automatic logic [1:0] nxt(input logic [1:0] g);
    logic [1:0] n;
    case (g)
      2'd0:    n = 2'd1;
      2'd1:    n = 2'd2;
      default: n = 2'd0;
    endcase
    return n;
  endfunction

  bstate_e               state_q;
  phase_e                ph_q;
  item_t                 item_q;
  norm_req_t             nreq_q;
  logic [1:0]            g_q;
  logic [1:0]            j_q;
  logic signed [63:0]    prod_q;
  logic signed [63:0]    acc_q;
  logic [2:0][63:0]      t_q;
  logic [2:0][2:0][31:0] ax_q;
  logic [2:0][31:0]      tr_q;
  logic                  ok_q;
  logic [1:0]            row_q;
  logic                  out_valid_q;
  logic [1:0]            out_row_q;
  logic [2:0][31:0]      out_axis_q;
  logic [31:0]           out_tr_q;
  logic                  out_deg_q;
  logic                  out_last_q;

  logic [1:0]            ia;
  logic [1:0]            ib;
  logic signed [31:0]    opa;
  logic signed [31:0]    opb;
  logic signed [63:0]    term;
  logic signed [63:0]    res;
  logic                  last_term;
  logic                  out_free;
  logic [2:0][31:0]      row_axis;
  logic [31:0]           row_tr;

  assign item_pop_o    = (state_q == B_IDLE) && item_valid_i;
  assign nreq_o        = nreq_q;
  assign out_valid_o   = out_valid_q;
  assign row_o         = out_row_q;
  assign axis_x_o      = out_axis_q[0];
  assign axis_y_o      = out_axis_q[1];
  assign axis_z_o      = out_axis_q[2];
  assign translation_o = out_tr_q;
  assign degenerate_o  = out_deg_q;
  assign last_o        = out_last_q;
  assign out_free      = !out_valid_q || out_ready_i;

  always_comb begin
    ia = nxt(g_q);
    ib = nxt(ia);
    case (ph_q)
      PH_T: begin
        opa = (j_q == 2'd0) ? item_q.up[ia] : item_q.up[ib];
        opb = (j_q == 2'd0) ? ax_q[2][ib] : ax_q[2][ia];
      end
      PH_Y: begin
        opa = (j_q == 2'd0) ? ax_q[2][ia] : ax_q[2][ib];
        opb = (j_q == 2'd0) ? ax_q[0][ib] : ax_q[0][ia];
      end
      default: begin
        opa = ax_q[g_q][j_q];
        opb = item_q.origin[j_q];
      end
    endcase
    term      = (ph_q != PH_D && j_q == 2'd1) ? -prod_q : prod_q;
    res       = ((j_q == 2'd0) ? 64'sd0 : acc_q) + term;
    last_term = (ph_q == PH_D) ? (j_q == 2'd2) : (j_q == 2'd1);
    case (row_q)
      2'd0:    begin row_axis = ax_q[0]; row_tr = tr_q[0]; end
      2'd1:    begin row_axis = ax_q[1]; row_tr = tr_q[1]; end
      default: begin row_axis = ax_q[2]; row_tr = tr_q[2]; end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_IDLE;
      ph_q        <= PH_T;
      item_q      <= '0;
      nreq_q      <= '0;
      g_q         <= '0;
      j_q         <= '0;
      prod_q      <= '0;
      acc_q       <= '0;
      t_q         <= '0;
      ax_q        <= '0;
      tr_q        <= '0;
      ok_q        <= 1'b0;
      row_q       <= '0;
      out_valid_q <= 1'b0;
      out_row_q   <= '0;
      out_axis_q  <= '0;
      out_tr_q    <= '0;
      out_deg_q   <= 1'b0;
      out_last_q  <= 1'b0;
    end else begin
      nreq_q.start <= 1'b0;
      if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        B_IDLE: begin
          if (item_valid_i) begin
            item_q <= item_i;
            row_q  <= '0;
            if (item_i.dir_zero) begin
              ok_q    <= 1'b0;
              state_q <= B_EMIT;
            end else begin
              nreq_q.start <= 1'b1;
              for (int i = 0; i < 3; i++) begin
                nreq_q.vec[i] <= {{32{item_i.dir[i][31]}}, item_i.dir[i]};
              end
              state_q <= B_NORM_Z;
            end
          end
        end
        B_NORM_Z: begin
          if (nrsp_i.done) begin
            if (!nrsp_i.ok) begin
              ok_q    <= 1'b0;
              state_q <= B_EMIT;
            end else begin
              for (int i = 0; i < 3; i++) begin
                ax_q[2][i] <= ~nrsp_i.axis[i] + 32'd1;
              end
              ph_q    <= PH_T;
              g_q     <= '0;
              j_q     <= '0;
              state_q <= B_MUL;
            end
          end
        end
        B_MUL: begin
          prod_q  <= opa * opb;
          state_q <= B_ACC;
        end
        B_ACC: begin
          if (!last_term) begin
            acc_q   <= res;
            j_q     <= j_q + 2'd1;
            state_q <= B_MUL;
          end else begin
            j_q <= '0;
            case (ph_q)
              PH_T:    t_q[g_q]     <= res;
              PH_Y:    ax_q[1][g_q] <= clamp_axis(round30(res));
              default: tr_q[g_q]    <= sat32(round30(-res));
            endcase
            if (g_q != 2'd2) begin
              g_q     <= g_q + 2'd1;
              state_q <= B_MUL;
            end else begin
              g_q <= '0;
              case (ph_q)
                PH_T: begin
                  nreq_q.start <= 1'b1;
                  nreq_q.vec   <= {res, t_q[1], t_q[0]};
                  state_q      <= B_NORM_X;
                end
                PH_Y: begin
                  ph_q    <= PH_D;
                  state_q <= B_MUL;
                end
                default: begin
                  ok_q    <= 1'b1;
                  state_q <= B_EMIT;
                end
              endcase
            end
          end
        end
        B_NORM_X: begin
          if (nrsp_i.done) begin
            if (!nrsp_i.ok) begin
              ok_q    <= 1'b0;
              state_q <= B_EMIT;
            end else begin
              ax_q[0] <= nrsp_i.axis;
              ph_q    <= PH_Y;
              g_q     <= '0;
              j_q     <= '0;
              state_q <= B_MUL;
            end
          end
        end
        B_EMIT: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            out_row_q   <= row_q;
            out_axis_q  <= ok_q ? row_axis : '0;
            out_tr_q    <= ok_q ? row_tr : '0;
            out_deg_q   <= !ok_q;
            out_last_q  <= (row_q == RowLast);
            if (row_q == RowLast) begin
              state_q <= B_IDLE;
            end else begin
              row_q <= row_q + 2'd1;
            end
          end
        end
        default: begin
          state_q <= B_IDLE;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

// ----- design/look_at_view_matrix_top.sv -----
// right-handed look-at view matrix, top level: front queue, back sequencer, normaliser
// the sequencer takes one item at a time; it pops the next from the queue only after
// row 2 of the current one is registered, and the rows leave in order as the output
// is ready; the normaliser (bit-serial square root and divider) runs for the z and
// then the x axis of each item and sets the item rate; a zero direction skips it
// the input queue holds two items; rst_ni clears all control state asynchronously
`default_nettype none
module look_at_view_matrix_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [31:0] origin_x_i,
  input  logic [31:0] origin_y_i,
  input  logic [31:0] origin_z_i,
  input  logic [31:0] dir_x_i,
  input  logic [31:0] dir_y_i,
  input  logic [31:0] dir_z_i,
  input  logic [31:0] up_x_i,
  input  logic [31:0] up_y_i,
  input  logic [31:0] up_z_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  row_o,
  output logic [31:0] axis_x_o,
  output logic [31:0] axis_y_o,
  output logic [31:0] axis_z_o,
  output logic [31:0] translation_o,
  output logic        degenerate_o,
  output logic        last_o
);
  import lvm_pkg::*;

  item_t     item;
  logic      item_valid;
  logic      item_pop;
  norm_req_t nreq;
  norm_rsp_t nrsp;

  lvm_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .origin_i     ({origin_z_i, origin_y_i, origin_x_i}),
    .dir_i        ({dir_z_i, dir_y_i, dir_x_i}),
    .up_i         ({up_z_i, up_y_i, up_x_i}),
    .pop_i        (item_pop),
    .item_valid_o (item_valid),
    .item_o       (item)
  );

  lvm_norm u_norm (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (nreq),
    .rsp_o  (nrsp)
  );

  lvm_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .item_valid_i  (item_valid),
    .item_i        (item),
    .item_pop_o    (item_pop),
    .nreq_o        (nreq),
    .nrsp_i        (nrsp),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .row_o         (row_o),
    .axis_x_o      (axis_x_o),
    .axis_y_o      (axis_y_o),
    .axis_z_o      (axis_z_o),
    .translation_o (translation_o),
    .degenerate_o  (degenerate_o),
    .last_o        (last_o)
  );

endmodule
`default_nettype wire

// ----- design/lvm_checker.sv -----
// port-level checker for look_at_view_matrix_top, bound to the top level
// depends on lvm_pkg and look_at_view_matrix_top_assert.svh
`default_nettype none
`include "look_at_view_matrix_top_assert.svh"
module lvm_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        in_valid_i,
  input wire logic        in_ready_o,
  input wire logic        out_valid_o,
  input wire logic        out_ready_i,
  input wire logic [1:0]  row_o,
  input wire logic [31:0] axis_x_o,
  input wire logic [31:0] axis_y_o,
  input wire logic [31:0] axis_z_o,
  input wire logic [31:0] translation_o,
  input wire logic        degenerate_o,
  input wire logic        last_o
);
  import lvm_pkg::*;

  logic [1:0] exp_row_q;
  logic [2:0] pend_q;
  logic       in_acc;
  logic       out_acc;

  assign in_acc  = in_valid_i && in_ready_o;
  assign out_acc = out_valid_o && out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      exp_row_q <= '0;
      pend_q    <= '0;
    end else begin
      if (out_acc) begin
        exp_row_q <= last_o ? 2'd0 : exp_row_q + 2'd1;
      end
      pend_q <= pend_q + 3'(in_acc) - 3'(out_acc && last_o);
    end
  end

  `LVM_ASSERT_IMP(row_order_a, out_valid_o, (row_o == exp_row_q) && (last_o == (row_o == RowLast)))
  `LVM_ASSERT_IMP(degen_zero_a, out_valid_o && degenerate_o,
    (axis_x_o == '0) && (axis_y_o == '0) && (axis_z_o == '0) && (translation_o == '0))
  `LVM_ASSERT_IMP(no_orphan_a, out_valid_o, pend_q != 3'd0)
  `LVM_ASSERT_NXT(pend_after_in_a, in_acc, pend_q != 3'd0)

endmodule

bind look_at_view_matrix_top lvm_checker u_chk (.*);
`default_nettype wire

// ----- dv/look_at_view_matrix_top_tb.sv -----
// testbench for the right-handed look-at view matrix block
// predicts three rows per item in fixed point and checks each row
// depends on lvm_pkg and look_at_view_matrix_top
`default_nettype none
module look_at_view_matrix_top_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import lvm_pkg::*;

  typedef struct packed {
    logic [1:0]  row;
    logic [31:0] ax;
    logic [31:0] ay;
    logic [31:0] az;
    logic [31:0] tr;
    logic        degen;
    logic        last;
  } view_row_t;

  localparam int unsigned StallLimit = 20000;
  localparam int unsigned DrainCycles = 800;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic [31:0] origin_x_i = '0, origin_y_i = '0, origin_z_i = '0;
  logic [31:0] dir_x_i = '0, dir_y_i = '0, dir_z_i = '0;
  logic [31:0] up_x_i = '0, up_y_i = '0, up_z_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic [1:0] row_o;
  logic [31:0] axis_x_o, axis_y_o, axis_z_o, translation_o;
  logic degenerate_o, last_o;

  view_row_t expected_rows[$];
  int unsigned fails = 0;
  int unsigned stall_cycles = 0;
  bit quiet = 1'b0;

  always #4 clk_i = ~clk_i;

  look_at_view_matrix_top u_dut (.*);

  function automatic logic [63:0] mag(longint v);
    return v < 0 ? 64'(-v) : 64'(v);
  endfunction

  function automatic longint round30(longint v);
    logic [63:0] m;
    m = (mag(v) + (64'd1 << 29)) >> 30;
    return v < 0 ? -longint'(m) : longint'(m);
  endfunction

  function automatic longint clamp_unit(longint v);
    if (v > (64'sd1 <<< 30)) return 64'sd1 <<< 30;
    if (v < -(64'sd1 <<< 30)) return -(64'sd1 <<< 30);
    return v;
  endfunction

  function automatic logic [63:0] int_sqrt(logic [63:0] x);
    logic [63:0] r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > x) b >>= 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic bit unit_vector(input longint v[3], output longint u[3]);
    logic [63:0] m[3];
    logic [63:0] mx, sum, len, q;
    int nb;
    mx = 0;
    sum = 0;
    nb = 0;
    for (int i = 0; i < 3; i++) begin
      m[i] = mag(v[i]);
      if (m[i] > mx) mx = m[i];
    end
    if (mx == 0) return 1'b0;
    while (nb < 64 && (mx >> nb) != 0) nb++;
    for (int i = 0; i < 3; i++) begin
      if (nb > 28) m[i] >>= (nb - 28);
      else m[i] <<= (28 - nb);
      sum += m[i] * m[i];
    end
    len = int_sqrt(sum << 6);
    if (len == 0) return 1'b0;
    for (int i = 0; i < 3; i++) begin
      q = ((m[i] << 33) + (len >> 1)) / len;
      if (q > 64'h4000_0000) q = 64'h4000_0000;
      u[i] = v[i] < 0 ? -longint'(q) : longint'(q);
    end
    return 1'b1;
  endfunction

  function automatic void predict_view(input logic [31:0] o[3], d[3], u[3]);
    longint org[3], dv[3], up[3], t[3], ax[3][3];
    longint dp, tr;
    bit ok;
    view_row_t r;
    for (int j = 0; j < 3; j++) begin
      org[j] = longint'($signed(o[j]));
      dv[j] = longint'($signed(d[j]));
      up[j] = longint'($signed(u[j]));
    end
    ok = unit_vector(dv, ax[2]);
    if (ok) begin
      for (int j = 0; j < 3; j++) ax[2][j] = -ax[2][j];
      t[0] = up[1] * ax[2][2] - up[2] * ax[2][1];
      t[1] = up[2] * ax[2][0] - up[0] * ax[2][2];
      t[2] = up[0] * ax[2][1] - up[1] * ax[2][0];
      ok = unit_vector(t, ax[0]);
    end
    if (ok) begin
      ax[1][0] = clamp_unit(round30(ax[2][1] * ax[0][2] - ax[2][2] * ax[0][1]));
      ax[1][1] = clamp_unit(round30(ax[2][2] * ax[0][0] - ax[2][0] * ax[0][2]));
      ax[1][2] = clamp_unit(round30(ax[2][0] * ax[0][1] - ax[2][1] * ax[0][0]));
    end
    for (int k = 0; k < 3; k++) begin
      r = '0;
      r.row = 2'(k);
      if (ok) begin
        dp = ax[k][0] * org[0] + ax[k][1] * org[1] + ax[k][2] * org[2];
        tr = round30(-dp);
        if (tr > 64'sd2147483647) tr = 64'sd2147483647;
        if (tr < -64'sd2147483648) tr = -64'sd2147483648;
        r.ax = 32'(ax[k][0]);
        r.ay = 32'(ax[k][1]);
        r.az = 32'(ax[k][2]);
        r.tr = 32'(tr);
      end
      r.degen = !ok;
      r.last = (2'(k) == RowLast);
      expected_rows.push_back(r);
    end
  endfunction

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(0, 5))
      0: return $urandom();
      1: return 32'($signed($urandom_range(0, 131072)) - 65536);
      2: return $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7fff_ffff;
      3: return 32'($signed($urandom_range(0, 2000)) - 1000);
      default: return 32'($signed($urandom_range(0, 2 ** 24)) - 2 ** 23);
    endcase
  endfunction

  task automatic send_view(input logic [31:0] o[3], d[3], u[3]);
    while (!quiet && $urandom_range(0, 99) < 36) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    {origin_x_i, origin_y_i, origin_z_i} <= {o[0], o[1], o[2]};
    {dir_x_i, dir_y_i, dir_z_i} <= {d[0], d[1], d[2]};
    {up_x_i, up_y_i, up_z_i} <= {u[0], u[1], u[2]};
    predict_view(o, d, u);
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task automatic test_directed();
    logic [31:0] o[3], d[3], u[3];
    o = '{0, 0, 0}; d = '{0, 0, 32'hffff_0000}; u = '{0, 32'h1_0000, 0};
    send_view(o, d, u);
    o = '{32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff};
    send_view(o, d, u);
    o = '{32'h8000_0000, 32'h8000_0000, 32'h8000_0000};
    d = '{32'h8000_0000, 32'h8000_0000, 32'h8000_0000};
    u = '{32'h7fff_ffff, 0, 32'h8000_0000};
    send_view(o, d, u);
    d = '{0, 0, 0};
    send_view(o, d, u);
    d = '{32'h1_0000, 32'h2_0000, 32'h3_0000};
    u = '{32'h2_0000, 32'h4_0000, 32'h6_0000};
    send_view(o, d, u);
    u = '{0, 0, 0};
    send_view(o, d, u);
    d = '{32'h7fff_ffff, 1, 0};
    u = '{32'h7fff_ffff, 0, 0};
    send_view(o, d, u);
    u = '{32'h7fff_fffe, 0, 1};
    o = '{32'h1234_5678, 32'hfedc_ba98, 32'hffff_ffff};
    send_view(o, d, u);
    d = '{1, 0, 0}; u = '{0, 1, 0};
    send_view(o, d, u);
    d = '{32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff}; u = '{1, 0, 0};
    send_view(o, d, u);
  endtask

  task automatic test_random(int unsigned n);
    logic [31:0] o[3], d[3], u[3];
    for (int unsigned i = 0; i < n; i++) begin
      quiet = (i >= n / 2 && i < n / 2 + 40);
      for (int j = 0; j < 3; j++) begin
        o[j] = rand_coord();
        d[j] = rand_coord();
        u[j] = rand_coord();
      end
      // near-parallel up and degenerate cases now and then
      case ($urandom_range(0, 9))
        0: u = d;
        1: for (int j = 0; j < 3; j++) u[j] = d[j] + 32'($urandom_range(0, 2));
        2: d = '{0, 0, 0};
        default: ;
      endcase
      send_view(o, d, u);
    end
    quiet = 1'b0;
  endtask

  always @(posedge clk_i) begin
    out_ready_i <= quiet || ($urandom_range(0, 99) >= 36);
  end

  always @(posedge clk_i) begin
    view_row_t e;
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) stall_cycles <= 0;
      else stall_cycles <= stall_cycles + 1;
      if (stall_cycles > StallLimit) begin
        $display("FAILURE");
        $finish;
      end
      if (out_valid_o && out_ready_i) begin
        if (expected_rows.size() == 0) begin
          $display("%0t unexpected row %0d", $time, row_o);
          fails++;
        end else begin
          e = expected_rows.pop_front();
          if (e != {row_o, axis_x_o, axis_y_o, axis_z_o, translation_o,
                    degenerate_o, last_o}) begin
            $display("%0t mismatch exp row %0d ax %h ay %h az %h tr %h dg %b last %b",
                     $time, e.row, e.ax, e.ay, e.az, e.tr, e.degen, e.last);
            $display("%0t          act row %0d ax %h ay %h az %h tr %h dg %b last %b",
                     $time, row_o, axis_x_o, axis_y_o, axis_z_o, translation_o,
                     degenerate_o, last_o);
            fails++;
          end
        end
      end
    end
  end

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_random(200);
    in_valid_i <= 1'b0;
    while (expected_rows.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (fails == 0 && expected_rows.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end
endmodule
`default_nettype wire
